// File: rtl/xpad_content_indicator_parser_assert.svh
// Assertion macros shared by the content indicator parser modules.
`ifndef XPAD_CONTENT_INDICATOR_PARSER_ASSERT_SVH
`define XPAD_CONTENT_INDICATOR_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define XCIP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define XCIP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/xcip_pkg.sv
// Shared types, codes and lookup functions of the content indicator parser.
package xcip_pkg;

	// Number of subfield slots carried in one parsed frame record.
	localparam int CI_SLOTS = 4;
	localparam int CNT_W    = $clog2(CI_SLOTS + 1);
	localparam int IDX_W    = $clog2(CI_SLOTS);

	// F-PAD codes.
	localparam logic [1:0] FPAD_TYPE_DATA = 2'b00;
	localparam logic [1:0] IND_SHORT      = 2'b01;
	localparam logic [1:0] IND_VAR        = 2'b10;

	// Content indicator codes.
	localparam logic [4:0] TYPE_END     = 5'd0;
	localparam logic [7:0] SHORT_CI_LEN = 8'd3;

	// Application types that carry a continuation.
	localparam logic [4:0] TYPE_CONT_A = 5'd1;
	localparam logic [4:0] TYPE_CONT_B = 5'd3;
	localparam logic [4:0] TYPE_CONT_C = 5'd13;

	// Application types that continue as a type of their own group.
	localparam logic [4:0] TYPE_CONT_B_ALT = 5'd2;
	localparam logic [4:0] TYPE_CONT_C_ALT = 5'd12;

	// Decoded view of one content indicator byte.
	typedef struct packed {
		logic [4:0] typ;
		logic [7:0] len;
		logic       is_end;
	} lane_t;

	// One parsed frame: subfield count and per-subfield fields.
	typedef struct packed {
		logic [CNT_W-1:0]          cnt;
		logic [CI_SLOTS-1:0][4:0] typ;
		logic [CI_SLOTS-1:0][7:0] off;
		logic [CI_SLOTS-1:0][7:0] len;
	} frame_t;

	// Continuation mapping result.
	typedef struct packed {
		logic       valid;
		logic [4:0] typ;
	} cont_t;

	// Length code of a variable-size content indicator.
	function automatic logic [7:0] ci_length(input logic [2:0] code);
		logic [7:0] r;
		unique case (code)
			3'd0: r = 8'd4;
			3'd1: r = 8'd6;
			3'd2: r = 8'd8;
			3'd3: r = 8'd12;
			3'd4: r = 8'd16;
			3'd5: r = 8'd24;
			3'd6: r = 8'd32;
			default: r = 8'd48;
		endcase
		return r;
	endfunction

	// Type that the following frame continues, if any.
	function automatic cont_t continued_type(input logic [4:0] t);
		cont_t r;
		r = '0;
		unique case (t) inside
			TYPE_CONT_A: begin
				r.valid = 1'b1;
				r.typ   = TYPE_CONT_A;
			end
			TYPE_CONT_B_ALT, TYPE_CONT_B: begin
				r.valid = 1'b1;
				r.typ   = TYPE_CONT_B;
			end
			TYPE_CONT_C_ALT, TYPE_CONT_C: begin
				r.valid = 1'b1;
				r.typ   = TYPE_CONT_C;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/xpad_content_indicator_parser.sv
// Top level of the X-PAD content indicator list parser.
// Flow: an accepted frame is stored in the pending register, then moves to the current-frame
// register, from which its first subfield is offered; a busy sender holds it in the pending register.
// A new frame can be taken while an earlier one is still being sent, if the pending register is free.
// The sender drains one subfield per cycle while out_stall is low, which sets the sustained rate.
// Reset clears the continuation and all buffered frames; no clearing pass is needed.
module xpad_content_indicator_parser #(
	parameter int MAX_CIS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] fpad_word,
	input  logic [7:0]  xpad_length,
	input  logic        exact_length,
	input  logic [7:0]  ci_byte_0,
	input  logic [7:0]  ci_byte_1,
	input  logic [7:0]  ci_byte_2,
	input  logic [7:0]  ci_byte_3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  subfield_type,
	output logic [7:0]  subfield_offset,
	output logic [7:0]  subfield_length,
	output logic        last_subfield
);

	logic [3:0][7:0]                 ci_bytes;
	xcip_pkg::lane_t [MAX_CIS-1:0]   lanes;
	xcip_pkg::frame_t                frm;
	logic                            frm_ok;
	logic                            can_take;
	logic                            in_fire;

	assign ci_bytes = {ci_byte_3, ci_byte_2, ci_byte_1, ci_byte_0};
	assign in_stall = !can_take;
	assign in_fire  = in_valid && !in_stall;

	// One decode lane per content indicator byte.
	for (genvar g = 0; g < MAX_CIS; g++) begin : g_lane
		xcip_lane u_lane (
			.ci_byte (ci_bytes[g]),
			.lane    (lanes[g])
		);
	end

	xcip_merge #(
		.MAX_CIS (MAX_CIS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.fpad_word    (fpad_word),
		.xpad_length  (xpad_length),
		.exact_length (exact_length),
		.lanes        (lanes),
		.frm          (frm),
		.frm_ok       (frm_ok)
	);

	// Only frames with a non-empty, length-checked list reach the sender.
	xcip_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.frm_load        (in_fire && frm_ok),
		.frm_in          (frm),
		.can_take        (can_take),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.subfield_type   (subfield_type),
		.subfield_offset (subfield_offset),
		.subfield_length (subfield_length),
		.last_subfield   (last_subfield)
	);

endmodule

// File: rtl/xcip_lane.sv
// One lane: decodes a single content indicator byte into type, length and end mark.
module xcip_lane (
	input  logic [7:0]           ci_byte,
	output xcip_pkg::lane_t      lane
);

	// Type in the low five bits, length code in the top three.
	always_comb begin
		lane.typ    = ci_byte[4:0];
		lane.len    = xcip_pkg::ci_length(ci_byte[7:5]);
		lane.is_end = (ci_byte[4:0] == xcip_pkg::TYPE_END);
	end

endmodule

// File: rtl/xcip_merge.sv
// Merge stage: combines the lane results into a subfield list and keeps the continuation.
`include "xpad_content_indicator_parser_assert.svh"

module xcip_merge #(
	parameter int MAX_CIS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_fire,
	input  logic [15:0]                     fpad_word,
	input  logic [7:0]                      xpad_length,
	input  logic                            exact_length,
	input  xcip_pkg::lane_t [MAX_CIS-1:0]   lanes,
	output xcip_pkg::frame_t                frm,
	output logic                            frm_ok
);

	logic [1:0]              ftype;
	logic [1:0]              ind;
	logic                    ci_flag;
	logic [2:0]              area;
	logic                    drop;
	logic [8:0]              total;
	logic                    len_fail;
	logic [4:0]              last_typ;
	xcip_pkg::cont_t         cont_nxt;
	xcip_pkg::frame_t        list_c;
	logic                    cont_type_good;

	logic                    cont_valid_q;
	logic [4:0]              cont_type_q;
	logic [7:0]              cont_length_q;

	assign ftype   = fpad_word[15:14];
	assign ind     = fpad_word[13:12];
	assign ci_flag = fpad_word[1];

	// Build the subfield list from the indicator mode and the lanes.
	always_comb begin
		logic stop;
		list_c = '0;
		area   = '0;
		drop   = 1'b0;
		stop   = 1'b0;
		if (ftype == xcip_pkg::FPAD_TYPE_DATA) begin
			if (ci_flag) begin
				if (ind == xcip_pkg::IND_SHORT) begin
					if (xpad_length == 8'd0) begin
						drop = 1'b1;
					end else if (!lanes[0].is_end) begin
						area          = 3'd1;
						list_c.cnt    = xcip_pkg::CNT_W'(1);
						list_c.typ[0] = lanes[0].typ;
						list_c.len[0] = xcip_pkg::SHORT_CI_LEN;
					end
				end else if (ind == xcip_pkg::IND_VAR) begin
					// Lanes up to and including the end marker form the CI area.
					for (int i = 0; i < MAX_CIS; i++) begin
						if (!stop) begin
							area = area + 3'd1;
							if (lanes[i].is_end) begin
								stop = 1'b1;
							end else begin
								list_c.typ[i] = lanes[i].typ;
								list_c.len[i] = lanes[i].len;
								list_c.cnt    = list_c.cnt + xcip_pkg::CNT_W'(1);
							end
						end
					end
					if ({5'd0, area} > xpad_length) begin
						drop = 1'b1;
					end
				end
			end else if ((ind == xcip_pkg::IND_SHORT || ind == xcip_pkg::IND_VAR)
					&& cont_valid_q) begin
				list_c.cnt    = xcip_pkg::CNT_W'(1);
				list_c.typ[0] = cont_type_q;
				list_c.len[0] = cont_length_q;
			end
		end
	end

	// Offsets follow the CI area; the running sum ends at the announced total.
	always_comb begin
		logic [8:0] acc;
		frm = list_c;
		acc = {6'd0, area};
		for (int i = 0; i < xcip_pkg::CI_SLOTS; i++) begin
			frm.off[i] = acc[7:0];
			if (xcip_pkg::CNT_W'(i) < list_c.cnt) begin
				acc = acc + {1'b0, list_c.len[i]};
			end
		end
		total = acc;
	end

	// Length check against the available X-PAD bytes.
	assign len_fail = exact_length ? (total != {1'b0, xpad_length})
	                               : (total > {1'b0, xpad_length});
	assign frm_ok   = (list_c.cnt != '0) && !drop && !len_fail;

	// Continuation candidate from the last subfield of the list.
	assign last_typ = list_c.typ[xcip_pkg::IDX_W'(list_c.cnt - xcip_pkg::CNT_W'(1))];
	assign cont_nxt = xcip_pkg::continued_type(last_typ);

	// Continuation state: every transaction clears it, a good list may set it again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_valid_q  <= 1'b0;
			cont_type_q   <= '0;
			cont_length_q <= '0;
		end else if (in_fire) begin
			cont_valid_q <= frm_ok && cont_nxt.valid;
			if (frm_ok && cont_nxt.valid) begin
				cont_type_q   <= cont_nxt.typ;
				cont_length_q <= total[7:0];
			end
		end
	end

	// A stored continuation always holds one of the continued types.
	assign cont_type_good = (cont_type_q == xcip_pkg::TYPE_CONT_A)
	                     || (cont_type_q == xcip_pkg::TYPE_CONT_B)
	                     || (cont_type_q == xcip_pkg::TYPE_CONT_C);

	`XCIP_ASSERT_IMP(a_ok_fits, frm_ok, total <= {1'b0, xpad_length}, "list too long")
	`XCIP_ASSERT_NXT(a_bad_clears, in_fire && !frm_ok, !cont_valid_q, "stale continuation")
	`XCIP_ASSERT_IMP(a_cont_type, cont_valid_q, cont_type_good, "bad continuation type")

endmodule

// File: rtl/xcip_emit.sv
// Output stage: buffers parsed frames and sends one subfield transaction per cycle while out_stall is low.
`include "xpad_content_indicator_parser_assert.svh"

module xcip_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frm_load,
	input  xcip_pkg::frame_t     frm_in,
	output logic                 can_take,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [4:0]           subfield_type,
	output logic [7:0]           subfield_offset,
	output logic [7:0]           subfield_length,
	output logic                 last_subfield
);

	logic                           pend_valid_q;
	xcip_pkg::frame_t               pend_s1;
	logic                           cur_valid_q;
	xcip_pkg::frame_t               cur_s2;
	logic [xcip_pkg::IDX_W-1:0]     idx_q;
	logic [xcip_pkg::CNT_W-1:0]     idx_ext;
	logic                           out_fire;
	logic                           is_last;
	logic                           cur_free;

	assign idx_ext  = {1'b0, idx_q};
	assign out_fire = cur_valid_q && !out_stall;
	assign is_last  = (idx_ext + xcip_pkg::CNT_W'(1)) == cur_s2.cnt;
	assign cur_free = !cur_valid_q || (out_fire && is_last);
	assign can_take = !pend_valid_q || cur_free;

	// Pending frame register between the merge stage and the sender.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (frm_load) begin
			pend_valid_q <= 1'b1;
		end else if (cur_free) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frm_load) begin
			pend_s1 <= frm_in;
		end
	end

	// Current frame and subfield index; the next frame moves in after the last subfield.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (cur_free) begin
			cur_valid_q <= pend_valid_q;
			idx_q       <= '0;
		end else if (out_fire) begin
			idx_q <= idx_q + xcip_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cur_free) begin
			cur_s2 <= pend_s1;
		end
	end

	// Result transaction fields.
	assign out_valid       = cur_valid_q;
	assign subfield_type   = cur_s2.typ[idx_q];
	assign subfield_offset = cur_s2.off[idx_q];
	assign subfield_length = cur_s2.len[idx_q];
	assign last_subfield   = is_last;

	`XCIP_ASSERT_IMP(a_cur_nonempty, cur_valid_q, cur_s2.cnt != '0, "empty frame in sender")
	`XCIP_ASSERT_IMP(a_idx_range, cur_valid_q, idx_ext < cur_s2.cnt, "subfield index past frame count")
	`XCIP_ASSERT_IMP(a_no_overwrite, frm_load, !pend_valid_q || cur_free, "pending frame overwritten")

endmodule
